[hdl/assert_macros.svh]
// Assertion macros used by the checker top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clk edge outside reset.
`define BFC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define BFC_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[hdl/bfc_pkg.sv]
// Types and constants of the battery-monitor frame checker.
package bfc_pkg;

	localparam logic [7:0] FRAME_START    = 8'hDD;
	localparam logic [7:0] FRAME_END      = 8'h77;
	localparam logic [8:0] FRAME_OVERHEAD = 9'd7;
	localparam logic [8:0] POSITION_LIMIT = 9'd263;
	localparam logic [7:0] REG_RESET      = 8'd3;

	typedef enum logic [2:0] {
		VERDICT_OK        = 3'd0,
		VERDICT_SHORT     = 3'd1,
		VERDICT_BAD_START = 3'd2,
		VERDICT_BAD_REG   = 3'd3,
		VERDICT_BAD_LEN   = 3'd4,
		VERDICT_BAD_SUM   = 3'd5,
		VERDICT_BAD_END   = 3'd6
	} verdict_t;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       last_byte;
	} rx_item_t;

	typedef struct packed {
		verdict_t   verdict;
		logic [7:0] payload_length;
	} result_t;

endpackage

[hdl/bms_frame_checker.sv]
// Top level of the battery-monitor reply frame checker.
// Checks a reply frame (0xDD, register, status, length L, L payload bytes,
// big-endian checksum, 0x77) one byte per item and, on the item flagged by
// tlast, emits one result: a verdict and the length byte, which is zero
// unless the verdict is ok. The first failing check wins, in the order:
// too short (under 7 bytes), start byte, register echo, length against byte
// count, checksum (zero minus the 16-bit sum of status, length and payload),
// end byte. The byte position saturates at 263, so buffers past 262 bytes
// fail the length check. Throughput is one byte per clock: a byte enters
// the input register, and the position compare and 16-bit add between that
// register and the result register settle it; the verdict of a frame is
// loaded into the result register from the input register when its last
// byte advances. Only a flagged byte waits on the result register, so the
// input stalls solely while a verdict is held by the downstream side.
module bms_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
	input  logic        s_axis_tlast,   // last_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [2:0] verdict, [10:3] payload_length, [15:11] zero
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata       // expected_register
);
	import bfc_pkg::*;

	`include "assert_macros.svh"

	logic       expected_register_q;
	logic [7:0] expected_reg_q;
	rx_item_t   item_in;
	rx_item_t   item_s1;
	logic       valid_s1;
	logic       in_load;
	logic       advance;
	logic       out_free;
	logic       out_load;
	result_t    result;
	result_t    result_q;

	// Hold the expected register code; the user must write it only while idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_reg_q      <= REG_RESET;
			expected_register_q <= 1'b0;
		end else if (cfg_we) begin
			expected_reg_q      <= cfg_wdata;
			expected_register_q <= 1'b1;
		end
	end

	assign item_in.rx_byte   = s_axis_tdata;
	assign item_in.last_byte = s_axis_tlast;

	// Advance a byte unless it is flagged and the result slot is busy
	assign advance       = valid_s1 && (!item_s1.last_byte || out_free);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_load       = s_axis_tvalid && s_axis_tready;
	assign out_load      = advance && item_s1.last_byte;

	bfc_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (in_load),
		.item_in  (item_in),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	bfc_frame_eval u_eval (
		.clk               (clk),
		.arst_n            (arst_n),
		.advance           (advance),
		.item_s1           (item_s1),
		.expected_register (expected_reg_q),
		.result            (result)
	);

	bfc_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.result_in (result),
		.ready     (m_axis_tready),
		.free      (out_free),
		.valid_q   (m_axis_tvalid),
		.result_q  (result_q)
	);

	assign m_axis_tdata = {5'd0, result_q.payload_length, result_q.verdict};

	// A failing verdict carries a zero length
	`BFC_ASSERT(a_len_zero_on_fail, (m_axis_tvalid && (result_q.verdict != VERDICT_OK)) |-> (result_q.payload_length == 8'd0), "length reported with failing verdict")
	// A blocked flagged byte must stall the input
	`BFC_ASSERT(a_stall_back, (valid_s1 && item_s1.last_byte && !out_free) |-> !s_axis_tready, "input taken while verdict blocked")
	// Never overwrite an untaken verdict
	`BFC_ASSERT_NEVER(a_no_overwrite, out_load && m_axis_tvalid && !m_axis_tready, "result overwritten before taken")
	// Configuration reaches the register on the next edge
	`BFC_ASSERT(a_cfg_taken, cfg_we |=> (expected_reg_q == $past(cfg_wdata)) && expected_register_q, "config write lost")

endmodule

[hdl/bfc_in_stage.sv]
// Input register of the frame checker.
module bfc_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  bfc_pkg::rx_item_t item_in,
	input  logic              advance,
	output logic              valid_s1,
	output bfc_pkg::rx_item_t item_s1
);
	import bfc_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload: no reset
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item_in;
		end
	end

endmodule

[hdl/bfc_frame_eval.sv]
// Per-frame state and verdict logic of the frame checker.
module bfc_frame_eval (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  bfc_pkg::rx_item_t item_s1,
	input  logic [7:0]        expected_register,
	output bfc_pkg::result_t  result
);
	import bfc_pkg::*;

	logic [8:0]  byte_position_q;
	logic [15:0] running_sum_q;
	logic [7:0]  length_field_q;
	logic [15:0] received_check_q;
	logic        start_bad_q;
	logic        register_bad_q;

	logic [8:0]  pos_d;
	logic [15:0] sum_d;
	logic [7:0]  len_d;
	logic [15:0] check_d;
	logic        start_bad_d;
	logic        register_bad_d;
	logic [8:0]  check_hi_pos;
	logic [8:0]  check_lo_pos;
	logic [15:0] sum_add;
	logic [15:0] expected_check;
	verdict_t    verdict;

	assign check_hi_pos = {1'b0, length_field_q} + 9'd4;
	assign check_lo_pos = {1'b0, length_field_q} + 9'd5;
	assign sum_add      = running_sum_q + {8'd0, item_s1.rx_byte};

	// Route the byte by its position in the frame
	always_comb begin
		sum_d          = running_sum_q;
		len_d          = length_field_q;
		check_d        = received_check_q;
		start_bad_d    = start_bad_q;
		register_bad_d = register_bad_q;
		if (byte_position_q == 9'd0) begin
			start_bad_d = (item_s1.rx_byte != FRAME_START);
		end else if (byte_position_q == 9'd1) begin
			register_bad_d = (item_s1.rx_byte != expected_register);
		end else if (byte_position_q == 9'd2) begin
			sum_d = sum_add;
		end else if (byte_position_q == 9'd3) begin
			len_d = item_s1.rx_byte;
			sum_d = sum_add;
		end else if (byte_position_q < check_hi_pos) begin
			sum_d = sum_add;
		end else if (byte_position_q == check_hi_pos) begin
			check_d = {item_s1.rx_byte, 8'h00};
		end else if (byte_position_q == check_lo_pos) begin
			check_d = {received_check_q[15:8], item_s1.rx_byte};
		end
		pos_d = (byte_position_q < POSITION_LIMIT) ? byte_position_q + 9'd1 : byte_position_q;
	end

	assign expected_check = 16'd0 - sum_d;

	// First failing check wins
	always_comb begin
		if (pos_d < FRAME_OVERHEAD) begin
			verdict = VERDICT_SHORT;
		end else if (start_bad_d) begin
			verdict = VERDICT_BAD_START;
		end else if (register_bad_d) begin
			verdict = VERDICT_BAD_REG;
		end else if ({1'b0, len_d} != pos_d - FRAME_OVERHEAD) begin
			verdict = VERDICT_BAD_LEN;
		end else if (expected_check != check_d) begin
			verdict = VERDICT_BAD_SUM;
		end else if (item_s1.rx_byte != FRAME_END) begin
			verdict = VERDICT_BAD_END;
		end else begin
			verdict = VERDICT_OK;
		end
		result.verdict        = verdict;
		result.payload_length = (verdict == VERDICT_OK) ? len_d : 8'd0;
	end

	// Clear after the marked byte, else hold the updated state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_position_q  <= '0;
			running_sum_q    <= '0;
			length_field_q   <= '0;
			received_check_q <= '0;
			start_bad_q      <= 1'b0;
			register_bad_q   <= 1'b0;
		end else if (advance) begin
			if (item_s1.last_byte) begin
				byte_position_q  <= '0;
				running_sum_q    <= '0;
				length_field_q   <= '0;
				received_check_q <= '0;
				start_bad_q      <= 1'b0;
				register_bad_q   <= 1'b0;
			end else begin
				byte_position_q  <= pos_d;
				running_sum_q    <= sum_d;
				length_field_q   <= len_d;
				received_check_q <= check_d;
				start_bad_q      <= start_bad_d;
				register_bad_q   <= register_bad_d;
			end
		end
	end

endmodule

[hdl/bfc_out_stage.sv]
// Result register of the frame checker.
module bfc_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  bfc_pkg::result_t result_in,
	input  logic             ready,
	output logic             free,
	output logic             valid_q,
	output bfc_pkg::result_t result_q
);
	import bfc_pkg::*;

	assign free = !valid_q || ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_in;
		end
	end

endmodule

[tb/bms_frame_checker_test.sv]
// Self-checking testbench for the battery-monitor reply frame checker.
module bms_frame_checker_test;
	import bfc_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int LONG_HOLD      = 300;
	localparam int RANDOM_ITEMS   = 620;

	// Ways a well-formed frame gets damaged before it is sent.
	typedef enum {
		FLAW_NONE,
		FLAW_START,
		FLAW_REGISTER,
		FLAW_LENGTH,
		FLAW_SUM,
		FLAW_PAYLOAD,
		FLAW_END,
		FLAW_DROP,
		FLAW_EXTRA
	} flaw_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] rx_byte
	logic        s_axis_tlast = 1'b0;    // last_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;           // [2:0] verdict, [10:3] payload_length
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = 8'h00;      // expected_register

	// Frame tracking state of the predictor.
	logic [8:0]  rx_pos;
	logic [15:0] sum_acc;
	logic [7:0]  len_byte;
	logic [15:0] chk_word;
	logic        start_wrong;
	logic        reg_wrong;
	logic [7:0]  reg_expect;

	result_t     pending_verdicts[$];
	logic [7:0]  frame_q[$];
	int          errors = 0;
	int          items_sent = 0;
	int          quiet_cycles = 0;
	int          hold_request = 0;
	bit          send_gaps = 1'b0;
	bit          recv_gaps = 1'b0;

	bms_frame_checker dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	task automatic clear_frame_state;
		rx_pos      = '0;
		sum_acc     = '0;
		len_byte    = '0;
		chk_word    = '0;
		start_wrong = 1'b0;
		reg_wrong   = 1'b0;
	endtask

	// Advance the frame state by one accepted byte; queue a verdict on a marked byte.
	task automatic predict_verdict(input logic [7:0] b, input logic last);
		logic [8:0]  p;
		logic [8:0]  body_end;
		logic [15:0] want_sum;
		verdict_t    v;
		result_t     r;
		p = rx_pos;
		body_end = 9'd4 + {1'b0, len_byte};
		if (p == 9'd0) begin
			start_wrong = (b != FRAME_START);
		end else if (p == 9'd1) begin
			reg_wrong = (b != reg_expect);
		end else if (p == 9'd2) begin
			sum_acc = sum_acc + 16'(b);
		end else if (p == 9'd3) begin
			len_byte = b;
			sum_acc = sum_acc + 16'(b);
		end else if (p < body_end) begin
			sum_acc = sum_acc + 16'(b);
		end else if (p == body_end) begin
			chk_word = {b, 8'h00};
		end else if (p == body_end + 9'd1) begin
			chk_word[7:0] = b;
		end
		if (rx_pos < POSITION_LIMIT)
			rx_pos = rx_pos + 9'd1;
		if (!last)
			return;
		want_sum = 16'd0 - sum_acc;
		if (rx_pos < FRAME_OVERHEAD)
			v = VERDICT_SHORT;
		else if (start_wrong)
			v = VERDICT_BAD_START;
		else if (reg_wrong)
			v = VERDICT_BAD_REG;
		else if ({1'b0, len_byte} != rx_pos - FRAME_OVERHEAD)
			v = VERDICT_BAD_LEN;
		else if (want_sum != chk_word)
			v = VERDICT_BAD_SUM;
		else if (b != FRAME_END)
			v = VERDICT_BAD_END;
		else
			v = VERDICT_OK;
		r.verdict = v;
		r.payload_length = (v == VERDICT_OK) ? len_byte : 8'h00;
		pending_verdicts.push_back(r);
		clear_frame_state();
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch: %s got %0d expected %0d (item %0d)", what, got, want, items_sent);
		errors++;
	endtask

	// Offer one byte, after a random gap when send_gaps is set, and hold it until the block takes it.
	task automatic send_item(input logic [7:0] b, input logic last);
		int gap;
		gap = send_gaps ? $urandom_range(0, 15) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tlast  <= last;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		predict_verdict(b, last);
		items_sent++;
	endtask

	task automatic send_buffer(input bit mark);
		foreach (frame_q[i])
			send_item(frame_q[i], mark && (i == frame_q.size() - 1));
	endtask

	// Drop valid, drain every verdict, then let bytes still in flight settle.
	task automatic settle_block;
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending_verdicts.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_expected_register(input logic [7:0] v);
		settle_block();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		reg_expect = v;
		cfg_we <= 1'b0;
	endtask

	// Fill frame_q with a well-formed frame of n payload bytes drawn from lo..hi.
	task automatic build_frame(input logic [7:0] reg_code, input int n, input int lo, input int hi);
		logic [7:0]  status;
		logic [7:0]  pb;
		logic [15:0] total;
		frame_q.delete();
		status = 8'($urandom_range(lo, hi));
		total = 16'(status) + 16'(n);
		frame_q.push_back(FRAME_START);
		frame_q.push_back(reg_code);
		frame_q.push_back(status);
		frame_q.push_back(8'(n));
		repeat (n) begin
			pb = 8'($urandom_range(lo, hi));
			total = total + 16'(pb);
			frame_q.push_back(pb);
		end
		total = 16'd0 - total;
		frame_q.push_back(total[15:8]);
		frame_q.push_back(total[7:0]);
		frame_q.push_back(FRAME_END);
	endtask

	task automatic apply_flaw(input flaw_t f);
		int k;
		logic [7:0] nz;
		nz = 8'($urandom_range(1, 255));
		k = frame_q.size();
		case (f)
			FLAW_START:    frame_q[0] ^= nz;
			FLAW_REGISTER: frame_q[1] ^= nz;
			FLAW_LENGTH:   frame_q[3] ^= nz;
			FLAW_SUM:      frame_q[k - 3 + $urandom_range(0, 1)] ^= nz;
			FLAW_PAYLOAD: begin
				// hit the status byte or a payload byte, never the length
				k = $urandom_range(4, k - 3);
				if (k == frame_q.size() - 3)
					k = 2;
				frame_q[k] ^= nz;
			end
			FLAW_END:      frame_q[k - 1] ^= nz;
			FLAW_DROP:     frame_q.delete($urandom_range(0, k - 1));
			FLAW_EXTRA:    frame_q.insert($urandom_range(0, k - 1), 8'($urandom_range(0, 255)));
			default: ;
		endcase
	endtask

	// Receive results after random stalls and compare each with the oldest verdict.
	initial begin : result_checker
		int      gap;
		result_t want;
		wait (arst_n === 1'b1);
		forever begin
			gap = recv_gaps ? $urandom_range(0, 15) : 0;
			if (hold_request > 0) begin
				gap = hold_request;
				hold_request = 0;
			end
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1);
			if (pending_verdicts.size() == 0) begin
				report_mismatch("result with none pending, tdata", int'(m_axis_tdata), 0);
			end else begin
				want = pending_verdicts.pop_front();
				if (m_axis_tdata[2:0] !== want.verdict)
					report_mismatch("verdict", int'(m_axis_tdata[2:0]), int'(want.verdict));
				if (m_axis_tdata[10:3] !== want.payload_length)
					report_mismatch("payload_length", int'(m_axis_tdata[10:3]),
						int'(want.payload_length));
			end
		end
	end

	// End the run once nothing has been accepted on either side for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("bms_frame_checker regression: fail");
			$finish;
		end
	end

	task automatic test_reset_register;
		build_frame(REG_RESET, 0, 0, 255);
		send_buffer(1'b1);
		build_frame(REG_RESET, 1, 255, 255);
		send_buffer(1'b1);
		build_frame(REG_RESET, 2, 0, 0);
		send_buffer(1'b1);
		build_frame(REG_RESET + 8'd1, 0, 0, 255);
		send_buffer(1'b1);
		settle_block();
	endtask

	// Buffers under the frame overhead, both valid prefixes and random bytes.
	task automatic test_short_buffers;
		for (int n = 1; n < 7; n++) begin
			build_frame(reg_expect, 0, 0, 255);
			frame_q = frame_q[0:n-1];
			send_buffer(1'b1);
			frame_q.delete();
			repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
			send_buffer(1'b1);
		end
		settle_block();
	endtask

	// Each failing check alone, then pairs to confirm which one wins.
	task automatic test_check_order;
		for (int f = FLAW_START; f <= FLAW_EXTRA; f++) begin
			build_frame(reg_expect, 2, 0, 255);
			apply_flaw(flaw_t'(f));
			send_buffer(1'b1);
		end
		build_frame(reg_expect, 1, 0, 255);
		apply_flaw(FLAW_START);
		apply_flaw(FLAW_REGISTER);
		send_buffer(1'b1);
		build_frame(reg_expect, 1, 0, 255);
		apply_flaw(FLAW_REGISTER);
		apply_flaw(FLAW_SUM);
		send_buffer(1'b1);
		build_frame(reg_expect, 3, 0, 255);
		apply_flaw(FLAW_SUM);
		apply_flaw(FLAW_END);
		send_buffer(1'b1);
		build_frame(reg_expect, 3, 0, 255);
		apply_flaw(FLAW_LENGTH);
		apply_flaw(FLAW_END);
		send_buffer(1'b1);
		settle_block();
	endtask

	task automatic test_register_values;
		logic [7:0] vals[3];
		vals = '{8'h00, 8'hFF, 8'($urandom_range(1, 254))};
		foreach (vals[i]) begin
			write_expected_register(vals[i]);
			build_frame(vals[i], 1, 0, 255);
			send_buffer(1'b1);
			build_frame(vals[i] ^ 8'h80, 1, 0, 255);
			send_buffer(1'b1);
		end
		settle_block();
	endtask

	// A write before the register byte applies to it; a write after does not.
	task automatic test_register_mid_frame;
		build_frame(8'h5A, 2, 0, 255);
		send_item(frame_q[0], 1'b0);
		write_expected_register(8'h5A);
		frame_q.pop_front();
		send_buffer(1'b1);
		build_frame(8'h5A, 2, 0, 255);
		send_item(frame_q[0], 1'b0);
		send_item(frame_q[1], 1'b0);
		write_expected_register(8'h11);
		frame_q = frame_q[2:$];
		send_buffer(1'b1);
		build_frame(8'h11, 0, 0, 255);
		send_buffer(1'b1);
		settle_block();
	endtask

	// Bytes without a marked last keep accumulating into the next buffer.
	task automatic test_unmarked_bytes;
		frame_q.delete();
		repeat (3) frame_q.push_back(8'($urandom_range(0, 255)));
		send_buffer(1'b0);
		build_frame(reg_expect, 1, 0, 255);
		send_buffer(1'b1);
		build_frame(reg_expect, 0, 0, 255);
		frame_q.pop_back();
		send_buffer(1'b0);
		build_frame(reg_expect, 2, 0, 255);
		send_buffer(1'b1);
		settle_block();
	endtask

	// Largest length, one byte over, and a buffer well past the position limit.
	task automatic test_long_buffers;
		build_frame(reg_expect, 255, 255, 255);
		send_buffer(1'b1);
		build_frame(reg_expect, 255, 0, 255);
		apply_flaw(FLAW_EXTRA);
		send_buffer(1'b1);
		build_frame(reg_expect, 255, 0, 255);
		repeat (40) frame_q.insert(frame_q.size() - 1, 8'($urandom_range(0, 255)));
		send_buffer(1'b1);
		settle_block();
	endtask

	// Hold the result side off for a long stretch while short frames keep coming.
	task automatic test_backpressure;
		send_gaps = 1'b0;
		hold_request = LONG_HOLD;
		repeat (30) begin
			build_frame(reg_expect, $urandom_range(0, 2), 0, 255);
			send_buffer(1'b1);
		end
		settle_block();
	endtask

	task automatic test_random;
		int stop_at;
		int pick;
		int n;
		stop_at = items_sent + RANDOM_ITEMS;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 39) == 0) begin
				send_gaps = $urandom_range(0, 1);
				recv_gaps = $urandom_range(0, 1);
			end
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				case ($urandom_range(0, 3))
					0:       write_expected_register(8'h00);
					1:       write_expected_register(8'hFF);
					default: write_expected_register(8'($urandom_range(0, 255)));
				endcase
			end else if (pick < 8) begin
				frame_q.delete();
				n = $urandom_range(1, 12);
				repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
				send_buffer(1'b1);
			end else if (pick < 10) begin
				frame_q.delete();
				n = $urandom_range(1, 4);
				repeat (n) frame_q.push_back(8'($urandom_range(0, 255)));
				send_buffer(1'b0);
			end else begin
				n = ($urandom_range(0, 99) == 0) ? $urandom_range(200, 255) : $urandom_range(0, 16);
				build_frame(reg_expect, n, 0, 255);
				if ($urandom_range(0, 2) == 0)
					apply_flaw(flaw_t'($urandom_range(FLAW_START, FLAW_EXTRA)));
				send_buffer(1'b1);
			end
		end
		settle_block();
	endtask

	initial begin
		reg_expect = REG_RESET;
		clear_frame_state();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_register();
		send_gaps = 1'b1;
		recv_gaps = 1'b1;
		test_short_buffers();
		test_check_order();
		test_register_values();
		test_register_mid_frame();
		test_unmarked_bytes();
		send_gaps = 1'b0;
		recv_gaps = 1'b0;
		test_long_buffers();
		test_backpressure();
		test_random();

		repeat (10) @(posedge clk);
		if (errors == 0 && pending_verdicts.size() == 0) begin
			$display("bms_frame_checker regression: pass");
		end else begin
			$display("bms_frame_checker regression: fail");
		end
		$finish;
	end

endmodule

[files.f]
+incdir+hdl
hdl/bfc_pkg.sv
hdl/bfc_in_stage.sv
hdl/bfc_frame_eval.sv
hdl/bfc_out_stage.sv
hdl/bms_frame_checker.sv
tb/bms_frame_checker_test.sv
